// ===== rtl/date_to_epoch_seconds_defines.svh =====
// Assertion macros for the calendar date to epoch seconds converter.
// Used by files that assert; expects signals named clock and reset in scope.
`ifndef DATE_TO_EPOCH_SECONDS_DEFINES_SVH
`define DATE_TO_EPOCH_SECONDS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define D2E_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define D2E_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/d2e_pkg.sv =====
// Shared types, constants and helper functions for the date to epoch converter.
// No dependencies; imported by every other file of the block but the defines header.
package d2e_pkg;

   // Field widths
   localparam int YEAR_W   = 7;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int EPOCH_W  = 32;
   localparam int OFFSET_W = 17;

   // Internal widths: day count since 1970 and seconds within the day
   localparam int DAYS_W = 16;
   localparam int TOD_W  = 17;
   localparam int DBM_W  = 9;

   // Days from 1970-01-01 to 2000-01-01 (thirty years, seven of them leap)
   localparam logic [DAYS_W-1:0] DAYS_TO_2000 = 16'd10957;
   localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 16'd365;
   // 2100 is the only century year in range that is not leap
   localparam logic [YEAR_W-1:0] CENTURY_YEAR = 7'd100;

   localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [TOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
   localparam logic [TOD_W-1:0]   SECS_PER_MIN  = 17'd60;

   localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 17'sd28800;

   // Days before the first of each month in a common year; codes past 12 take the whole year
   localparam logic [DBM_W-1:0] CUM_DAYS [16] = '{
      9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
   };

   // Payload between the calendar stage and the scaling stage
   typedef struct packed {
      logic [DAYS_W-1:0] days;
      logic [TOD_W-1:0]  tod;
   } d2e_mid_type;

   // Days in the earlier months of the year, with the leap day after February
   function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] month,
                                                          input logic leap);
      logic [DBM_W-1:0] total;
      total = CUM_DAYS[month];
      if (leap && (month inside {[4'd3:4'd15]})) begin
         total = total + 9'd1;
      end
      return total;
   endfunction

endpackage

// ===== rtl/d2e_req_if.sv =====
// Request channel carrying one calendar date and time of day per item.
// Depends on d2e_pkg for field widths.
interface d2e_req_if;
   import d2e_pkg::*;

   logic                valid;
   logic                ready;
   logic [YEAR_W-1:0]   year_since_2000;
   logic [MONTH_W-1:0]  month_number;
   logic [DAY_W-1:0]    day_of_month;
   logic [HOUR_W-1:0]   hour_of_day;
   logic [MINUTE_W-1:0] minute_of_hour;
   logic [SECOND_W-1:0] second_of_minute;

   modport source (
      output valid, year_since_2000, month_number, day_of_month,
             hour_of_day, minute_of_hour, second_of_minute,
      input  ready
   );

   modport sink (
      input  valid, year_since_2000, month_number, day_of_month,
             hour_of_day, minute_of_hour, second_of_minute,
      output ready
   );
endinterface

// ===== rtl/d2e_rsp_if.sv =====
// Response channel carrying one epoch second count per item.
// Depends on d2e_pkg for the field width.
interface d2e_rsp_if;
   import d2e_pkg::*;

   logic               valid;
   logic               ready;
   logic [EPOCH_W-1:0] epoch_seconds;

   modport source (output valid, epoch_seconds, input ready);
   modport sink (input valid, epoch_seconds, output ready);
endinterface

// ===== rtl/date_to_epoch_seconds.sv =====
// Top level of the calendar date to epoch seconds converter.
// Depends on d2e_pkg, d2e_req_if, d2e_rsp_if, d2e_calendar, d2e_scale and the defines header.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   req_ch   | in        | year_since_2000, month_number, day_of_month,
//            |           | hour_of_day, minute_of_hour, second_of_minute
//   rsp_ch   | out       | epoch_seconds
//   csr_*    | in        | zone_offset_seconds (write only, 17 bit signed)
//
// An accepted item is registered in the calendar stage, then in the result register, before it appears on rsp_ch.
// One item is accepted every cycle while rsp_ch does not stall; the two stage registers set the pace.
// A stalled result holds its stage and back-pressures the stage before it.
// Reset empties both stages and loads the zone offset with eight hours.
`include "date_to_epoch_seconds_defines.svh"

module date_to_epoch_seconds (
   input  logic                         clock,
   input  logic                         reset,
   d2e_req_if.sink                      req_ch,
   d2e_rsp_if.source                    rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [d2e_pkg::OFFSET_W-1:0] csr_wr_data
);
   import d2e_pkg::*;

   logic signed [OFFSET_W-1:0] offset_ff;
   logic                       mid_valid;
   logic                       mid_ready;
   d2e_mid_type                mid;

   // Zone offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         offset_ff <= signed'(csr_wr_data);
      end
   end

   // Date and time to day count and seconds of day
   d2e_calendar u_calendar (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .mid_valid (mid_valid),
      .mid       (mid),
      .mid_ready (mid_ready)
   );

   // Day count to epoch seconds, offset removed
   d2e_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .mid_valid   (mid_valid),
      .mid         (mid),
      .mid_ready   (mid_ready),
      .zone_offset (offset_ff),
      .rsp         (rsp_ch)
   );

   `D2E_ASSERT_NOW(a_req_ready_when_empty, !mid_valid, req_ch.ready, "request not ready with first stage empty")
   `D2E_ASSERT_NEXT(a_mid_moves_to_result, mid_valid && mid_ready, rsp_ch.valid, "item lost between stages")
   `D2E_ASSERT_NEXT(a_offset_written, csr_wr_en, offset_ff == $past(csr_wr_data), "zone offset write not taken")
endmodule

// ===== rtl/d2e_calendar.sv =====
// First pipeline stage: turns the date into a day count since 1970 and the
// time of day into seconds. Depends on d2e_pkg and d2e_req_if.
module d2e_calendar (
   input  logic                clock,
   input  logic                reset,
   d2e_req_if.sink             req,
   output logic                mid_valid,
   output d2e_pkg::d2e_mid_type mid,
   input  logic                mid_ready
);
   import d2e_pkg::*;

   logic        valid_ff, valid_in;
   d2e_mid_type mid_ff, mid_in;

   logic [YEAR_W-1:0] year;
   logic              leap;
   logic [5:0]        leaps;
   logic [DAYS_W-1:0] year_days;
   logic [DAYS_W-1:0] days_in_year;

   // Take a new item when the stage is empty or draining this cycle
   assign req.ready = !valid_ff || mid_ready;

   // Leap flag and day counts; leap days in the years from 2000 before the given year, 2100 excluded
   always_comb begin
      year  = req.year_since_2000;
      leap  = (year[1:0] == 2'b00) && (year != CENTURY_YEAR);
      leaps = 6'((({1'b0, year} + 8'd3) >> 2) - ((year > CENTURY_YEAR) ? 8'd1 : 8'd0));
      year_days = DAYS_TO_2000 + 16'(year) * DAYS_PER_YEAR + 16'(leaps);
      days_in_year = 16'(days_before_month(req.month_number, leap))
                     + 16'(req.day_of_month) - 16'd1;
   end

   // Day count and seconds of the day
   always_comb begin
      mid_in.days = year_days + days_in_year;
      mid_in.tod  = 17'(req.hour_of_day) * SECS_PER_HOUR
                    + 17'(req.minute_of_hour) * SECS_PER_MIN
                    + 17'(req.second_of_minute);
   end

   // Advance the stage valid flag
   always_comb begin
      valid_in = valid_ff;
      if (req.ready) begin
         valid_in = req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the payload on an accepted item
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = valid_ff;
   assign mid       = mid_ff;
endmodule

// ===== rtl/d2e_scale.sv =====
// Second pipeline stage: scales days to seconds, adds the time of day and
// removes the zone offset. Depends on d2e_pkg and d2e_rsp_if.
module d2e_scale (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           mid_valid,
   input  d2e_pkg::d2e_mid_type           mid,
   output logic                           mid_ready,
   input  logic signed [d2e_pkg::OFFSET_W-1:0] zone_offset,
   d2e_rsp_if.source                      rsp
);
   import d2e_pkg::*;

   logic               valid_ff, valid_in;
   logic [EPOCH_W-1:0] secs_ff, secs_in;
   logic [EPOCH_W-1:0] offset_ext;

   // Accept from the first stage when the result register is free or being taken
   assign mid_ready = !valid_ff || rsp.ready;

   // Seconds since 1970, wrapped to 32 bits
   always_comb begin
      offset_ext = {{(EPOCH_W-OFFSET_W){zone_offset[OFFSET_W-1]}}, zone_offset};
      secs_in    = 32'(mid.days) * SECS_PER_DAY + 32'(mid.tod) - offset_ext;
   end

   // Advance the result valid flag
   always_comb begin
      valid_in = valid_ff;
      if (mid_ready) begin
         valid_in = mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (mid_valid && mid_ready) begin
         secs_ff <= secs_in;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.epoch_seconds = secs_ff;
endmodule
